@@ hw/rtl/rmma_pkg.sv @@
package rmma_pkg;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0]  DIM_RST   = 4'd8;
  localparam logic [DATA_W-1:0] ALPHA_RST = 16'h1000;
  localparam logic [DATA_W-1:0] BETA_RST  = 16'h0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_LOAD_C = 2'd2,
    REQ_START  = 2'd3
  } rmma_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M  = 3'd0,
    CFG_COLS_N  = 3'd1,
    CFG_INNER_K = 3'd2,
    CFG_ALPHA   = 3'd3,
    CFG_BETA    = 3'd4
  } rmma_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } rmma_state_t;

  typedef struct packed {
    logic issue;
    logic clr;
    logic scale;
    logic use_c;
  } rmma_mac_ctl_t;

endpackage

@@ hw/rtl/rmma_if.sv @@
interface rmma_in_if;
  import rmma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface rmma_out_if;
  import rmma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] result;
  logic                     saturated;
  logic                     last;

  modport source (output valid, out_row, out_col, result, saturated, last, input ready);
  modport sink   (input valid, out_row, out_col, result, saturated, last, output ready);
endinterface

@@ hw/rtl/rmma_store.sv @@
module rmma_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic signed [rmma_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [ADDR_W-1:0]                 raddr,
  output logic signed [rmma_pkg::DATA_W-1:0] rdata
);
  import rmma_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/rmma_mac.sv @@
module rmma_mac #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmma_pkg::rmma_mac_ctl_t            ctl,
  input  logic signed [rmma_pkg::DATA_W-1:0] a_i,
  input  logic signed [rmma_pkg::DATA_W-1:0] b_i,
  input  logic signed [rmma_pkg::DATA_W-1:0] c_i,
  input  logic signed [rmma_pkg::DATA_W-1:0] alpha_i,
  input  logic signed [rmma_pkg::DATA_W-1:0] beta_i,
  output logic signed [rmma_pkg::DATA_W-1:0] res_o,
  output logic                               sat_o
);
  import rmma_pkg::*;

  localparam int MUL_W  = 2 * DATA_W;
  localparam int ACC_W  = MUL_W + $clog2(MAX_DIM);
  localparam int DOTQ_W = ACC_W - FRAC_BITS;
  localparam int TA_W   = DATA_W + DOTQ_W;
  localparam int PROD_W = ACC_W + DATA_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] NEG_LIM = SUM_W'(-32768);

  logic                     rd_v_r;
  logic                     prod_v_r;
  logic signed [MUL_W-1:0]  prod_r;
  logic signed [MUL_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DOTQ_W-1:0] dotq;
  logic signed [TA_W-1:0]   ta_mul;
  logic signed [PROD_W-1:0] ta_r;
  logic signed [PROD_W-1:0] ta_nxt;
  logic signed [MUL_W-1:0]  tb_r;
  logic signed [MUL_W-1:0]  tb_nxt;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shr;

  // read data shows up in the cycle after the issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= ctl.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_comb begin
    prod_nxt = MUL_W'(a_i) * MUL_W'(b_i);
    dotq     = DOTQ_W'(acc_r >>> FRAC_BITS);
    ta_mul   = alpha_i * dotq;
    ta_nxt   = PROD_W'(ta_mul);
    // drop old C entirely when beta is zero; it may never have been loaded
    tb_nxt   = ctl.use_c ? MUL_W'(beta_i) * MUL_W'(c_i) : '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.scale) begin
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
    end
  end

  always_comb begin
    sum = SUM_W'(ta_r) + SUM_W'(tb_r);
    shr = sum >>> FRAC_BITS;
    if (shr > POS_LIM) begin
      res_o = 16'sh7fff;
      sat_o = 1'b1;
    end else if (shr < NEG_LIM) begin
      res_o = 16'sh8000;
      sat_o = 1'b1;
    end else begin
      res_o = shr[DATA_W-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

@@ hw/rtl/real_matrix_multiply_accumulate_top.sv @@
// Channel   Dir  Handshake        Payload
// in_chan   in   valid / ready    req_type, row, col, value
// out_chan  out  valid / ready    out_row, out_col, result, saturated, last
// cfg       in   cfg_we           cfg_idx, cfg_wdata
//
// A start computes each C element in turn: multiply-accumulate on the single
// MAC (one read port on each of the A and B stores), with no MAC issue when K
// or alpha is zero, then drain, scale and emit.
// Reset is synchronous and clears only control state; the stores hold garbage
// until loaded. A stalled output holds the sequencer in its emit step.
module real_matrix_multiply_accumulate_top #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rmma_in_if.sink                              in_chan,
  rmma_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [rmma_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [rmma_pkg::DATA_W-1:0]          cfg_wdata
);
  import rmma_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    elem_addr = ADDR_W'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  // configuration
  logic [DIM_W-1:0]         rows_m_r;
  logic [DIM_W-1:0]         cols_n_r;
  logic [DIM_W-1:0]         inner_k_r;
  logic signed [DATA_W-1:0] alpha_r;
  logic signed [DATA_W-1:0] beta_r;

  logic [DIM_W-1:0] m_c;
  logic [DIM_W-1:0] n_c;
  logic [DIM_W-1:0] kk_c;
  logic             use_prod;
  logic             use_c;

  // sequencer
  rmma_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             drn_r, drn_nxt;
  rmma_mac_ctl_t    ctl;
  logic             c_re;
  logic             emit;
  logic             last_elem;

  logic             in_fire;
  logic             ld_ok;
  logic [ADDR_W-1:0] ld_addr;
  logic             a_we;
  logic             b_we;
  logic             c_we;
  logic [ADDR_W-1:0] c_waddr;
  logic signed [DATA_W-1:0] c_wdata;

  logic signed [DATA_W-1:0] a_rdata;
  logic signed [DATA_W-1:0] b_rdata;
  logic signed [DATA_W-1:0] c_rdata;
  logic signed [DATA_W-1:0] res;
  logic                     sat;

  // output register
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic signed [DATA_W-1:0] out_result_r;
  logic                     out_sat_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_RST;
      cols_n_r  <= DIM_RST;
      inner_k_r <= DIM_RST;
      alpha_r   <= ALPHA_RST;
      beta_r    <= BETA_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS_M:  rows_m_r  <= cfg_wdata[DIM_W-1:0];
        CFG_COLS_N:  cols_n_r  <= cfg_wdata[DIM_W-1:0];
        CFG_INNER_K: inner_k_r <= cfg_wdata[DIM_W-1:0];
        CFG_ALPHA:   alpha_r   <= cfg_wdata;
        CFG_BETA:    beta_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_c      = (rows_m_r > DIM_MAX) ? DIM_MAX : rows_m_r;
    n_c      = (cols_n_r > DIM_MAX) ? DIM_MAX : cols_n_r;
    kk_c     = (inner_k_r > DIM_MAX) ? DIM_MAX : inner_k_r;
    use_prod = (kk_c != '0) && (alpha_r != '0);
    use_c    = (beta_r != '0);
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign last_elem = ({1'b0, i_r} == m_c - 4'd1) && ({1'b0, j_r} == n_c - 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    drn_r <= drn_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    drn_nxt   = drn_r;
    ctl       = '0;
    ctl.use_c = use_c;
    c_re      = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_chan.req_type == REQ_START) && (m_c != '0) && (n_c != '0)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          ctl.clr   = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        c_re = 1'b1;
        if (use_prod) begin
          ctl.issue = 1'b1;
          if ({1'b0, k_r} == kk_c - 4'd1) begin
            drn_nxt   = 1'b0;
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end else begin
          drn_nxt   = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait out the read and the product register
        if (drn_r) begin
          state_nxt = ST_SCALE;
        end else begin
          drn_nxt = 1'b1;
        end
      end
      ST_SCALE: begin
        ctl.scale = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          emit    = 1'b1;
          ctl.clr = 1'b1;
          k_nxt   = '0;
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            if ({1'b0, j_r} == n_c - 4'd1) begin
              j_nxt = '0;
              i_nxt = i_r + 3'd1;
            end else begin
              j_nxt = j_r + 3'd1;
            end
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // loads outside the store are dropped
  always_comb begin
    ld_ok   = (32'(in_chan.row) < MAX_DIM) && (32'(in_chan.col) < MAX_DIM);
    ld_addr = elem_addr(in_chan.row, in_chan.col);
    a_we    = in_fire && ld_ok && (in_chan.req_type == REQ_LOAD_A);
    b_we    = in_fire && ld_ok && (in_chan.req_type == REQ_LOAD_B);
    c_we    = emit || (in_fire && ld_ok && (in_chan.req_type == REQ_LOAD_C));
    c_waddr = emit ? elem_addr(i_r, j_r) : ld_addr;
    c_wdata = emit ? res : in_chan.value;
  end

  rmma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (ld_addr),
    .wdata (in_chan.value),
    .re    (ctl.issue),
    .raddr (elem_addr(i_r, k_r)),
    .rdata (a_rdata)
  );

  rmma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (ld_addr),
    .wdata (in_chan.value),
    .re    (ctl.issue),
    .raddr (elem_addr(k_r, j_r)),
    .rdata (b_rdata)
  );

  rmma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_c_store (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (elem_addr(i_r, j_r)),
    .rdata (c_rdata)
  );

  rmma_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .a_i     (a_rdata),
    .b_i     (b_rdata),
    .c_i     (c_rdata),
    .alpha_i (alpha_r),
    .beta_i  (beta_r),
    .res_o   (res),
    .sat_o   (sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r    <= i_r;
      out_col_r    <= j_r;
      out_result_r <= res;
      out_sat_r    <= sat;
      out_last_r   <= last_elem;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_row   = out_row_r;
  assign out_chan.out_col   = out_col_r;
  assign out_chan.result    = out_result_r;
  assign out_chan.saturated = out_sat_r;
  assign out_chan.last      = out_last_r;

endmodule

@@ hw/rtl/rmma_checker.sv @@
module rmma_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [rmma_pkg::REQ_W-1:0]         in_req_type,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [rmma_pkg::IDX_W-1:0]         out_row,
  input logic [rmma_pkg::IDX_W-1:0]         out_col,
  input logic signed [rmma_pkg::DATA_W-1:0] out_result,
  input logic                               out_last
);
  import rmma_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("stalled result changed");

  // no input is taken mid-run, checked when a result other than the last is accepted
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("input taken during a run");

  // a load produces no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != REQ_START) && !out_valid |=> !out_valid)
    else $error("result after a load");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind real_matrix_multiply_accumulate_top rmma_checker u_rmma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_req_type (in_chan.req_type),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_row     (out_chan.out_row),
  .out_col     (out_chan.out_col),
  .out_result  (out_chan.result),
  .out_last    (out_chan.last)
);
